// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst_n is low
`define PHC_ASSERT_NOW(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication, disabled while rst_n is low
`define PHC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ----- hdl/phc_pkg.sv -----
// shared types and constants of the permutation half crossover
`default_nettype none
package phc_pkg;
    localparam int ELEM_W = 6;
    localparam int LEN_W  = 7;
    localparam int MAP_W  = 2 ** ELEM_W;

    localparam int C_MAX_LENGTH = 64;

    typedef logic [ELEM_W-1:0] t_elem;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [MAP_W-1:0]  t_map;

    localparam t_len C_MIN_LENGTH = 7'd2;
    localparam t_len C_LEN_RESET  = 7'd64;
    localparam t_len C_COUNT_MAX  = 7'd127;

    localparam logic C_KIND_PARENT_ONE = 1'b0;
    localparam logic C_KIND_PARENT_TWO = 1'b1;

    // decision for the element held in the input register
    typedef struct packed {
        logic emit;
        logic last;
    } t_decision;
endpackage
`default_nettype wire

// ----- hdl/phc_in_if.sv -----
// input stream interface: parent elements
`default_nettype none
interface phc_in_if;
    import phc_pkg::*;
    logic  valid;
    logic  ready;
    logic  kind;
    t_elem element;

    modport source(output valid, output kind, output element, input ready);
    modport sink(input valid, input kind, input element, output ready);
endinterface
`default_nettype wire

// ----- hdl/phc_out_if.sv -----
// output stream interface: child elements
`default_nettype none
interface phc_out_if;
    import phc_pkg::*;
    logic  valid;
    logic  ready;
    t_elem child_element;
    logic  child_last;

    modport source(output valid, output child_element, output child_last, input ready);
    modport sink(input valid, input child_element, input child_last, output ready);
endinterface
`default_nettype wire

// ----- hdl/permutation_half_crossover_top.sv -----
// top level of the permutation half crossover
// an emitted child element passes the input register and then the result register
// throughput: one input element per cycle while the output is not stalled, set by the single decision stage
// a dropped element leaves the input register without waiting on the output side
// reset: synchronous active low, clears bitmap, counters and valid flags;
// perm_length returns to 64
`default_nettype none
module permutation_half_crossover_top #(
    parameter int MAX_LENGTH = phc_pkg::C_MAX_LENGTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire phc_pkg::t_len i_cfg_wdata,
    phc_in_if.sink             i_in,
    phc_out_if.source          o_out
);
    import phc_pkg::*;

    t_len      r_perm_length;
    logic      r_in_valid;
    logic      r_in_kind;
    t_elem     r_in_element;
    logic      r_out_valid;
    t_elem     r_out_element;
    logic      r_out_last;
    t_decision decision;
    logic      out_free;
    logic      advance;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_length <= C_LEN_RESET;
        end else if (i_cfg_we) begin
            r_perm_length <= i_cfg_wdata;
        end
    end

    // handshake control
    assign out_free   = ~r_out_valid | o_out.ready;
    assign advance    = r_in_valid & (~decision.emit | out_free);
    assign i_in.ready = ~r_in_valid | advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_kind    <= i_in.kind;
            r_in_element <= i_in.element;
        end
    end

    // decision logic and state
    phc_core #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_perm_length (r_perm_length),
        .i_kind        (r_in_kind),
        .i_element     (r_in_element),
        .i_step        (advance),
        .o_decision    (decision)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && decision.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && decision.emit) begin
            r_out_element <= r_in_element;
            r_out_last    <= decision.last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.child_element = r_out_element;
    assign o_out.child_last    = r_out_last;
endmodule
`default_nettype wire

// ----- hdl/phc_core.sv -----
// crossover state: seen bitmap, counters and the per-element decision
`default_nettype none
module phc_core #(
    parameter int MAX_LENGTH = phc_pkg::C_MAX_LENGTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire phc_pkg::t_len     i_perm_length,
    input  wire logic              i_kind,
    input  wire phc_pkg::t_elem    i_element,
    input  wire logic              i_step,
    output phc_pkg::t_decision     o_decision
);
    import phc_pkg::*;

    localparam t_len MAX_LEN = t_len'(MAX_LENGTH);

    t_map r_seen_map, n_seen_map;
    t_len r_p1_count, n_p1_count;
    t_len r_child_count, n_child_count;

    t_len len_eff;
    t_len half;
    t_len child_next;
    logic head_slot;

    // clamp the length register into the supported range
    always_comb begin
        if (i_perm_length < C_MIN_LENGTH) begin
            len_eff = C_MIN_LENGTH;
        end else if (i_perm_length > MAX_LEN) begin
            len_eff = MAX_LEN;
        end else begin
            len_eff = i_perm_length;
        end
    end

    assign half       = len_eff >> 1;
    assign head_slot  = (r_p1_count < half);
    assign child_next = r_child_count + 7'd1;

    // emit decision for the held element
    always_comb begin
        if (i_kind == C_KIND_PARENT_ONE) begin
            o_decision.emit = head_slot;
        end else begin
            o_decision.emit = ~r_seen_map[i_element];
        end
        o_decision.last = (child_next >= len_eff);
    end

    // state update when the held element moves on
    always_comb begin
        n_seen_map    = r_seen_map;
        n_p1_count    = r_p1_count;
        n_child_count = r_child_count;
        if (i_step) begin
            if (i_kind == C_KIND_PARENT_ONE) begin
                if (head_slot) begin
                    n_seen_map[i_element] = 1'b1;
                end
                if (r_p1_count < C_COUNT_MAX) begin
                    n_p1_count = r_p1_count + 7'd1;
                end
            end
            if (o_decision.emit) begin
                if (o_decision.last) begin
                    n_seen_map    = '0;
                    n_p1_count    = '0;
                    n_child_count = '0;
                end else begin
                    n_child_count = child_next;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_map    <= '0;
            r_p1_count    <= '0;
            r_child_count <= '0;
        end else begin
            r_seen_map    <= n_seen_map;
            r_p1_count    <= n_p1_count;
            r_child_count <= n_child_count;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/phc_checker.sv -----
// port-level checker for the permutation half crossover, with its bind
`default_nettype none
`include "assert_macros.svh"
module phc_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_ready,
    input wire logic           i_out_valid,
    input wire logic           i_out_ready,
    input wire phc_pkg::t_elem i_out_element,
    input wire logic           i_out_last
);
    import phc_pkg::*;

    logic out_stall;
    assign out_stall = i_out_valid & ~i_out_ready;

    // a stalled child transaction stays offered
    `PHC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid, "output valid dropped")
    // and keeps its payload
    `PHC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(i_out_element) && $stable(i_out_last), "output payload changed")
    // input backpressure only comes from a stalled output
    `PHC_ASSERT_NOW(a_in_backpressure, i_clk, i_rst_n, !i_in_ready, out_stall, "input stalled without output stall")
    // reset empties the result register
    `PHC_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !i_out_valid, "output valid after reset")
endmodule

bind permutation_half_crossover_top phc_checker u_phc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_element (o_out.child_element),
    .i_out_last    (o_out.child_last)
);
`default_nettype wire

// ----- sim/tb.sv -----
// testbench of the permutation half crossover: directed rows, then random parent streams
`timescale 1ns / 1ps
module tb;
    import phc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 4;
    localparam int END_CYCLES   = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int ITEM_TARGET  = 950;
    localparam int FLOOD_COUNT  = 130;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_PATTERN, RX_HEAVY} t_rx_mode;
    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_DROP, CHK_EMIT} t_check;

    typedef struct packed {
        t_elem element;
        logic  last;
    } t_child;

    typedef struct packed {
        t_row_kind row_kind;
        t_len      value;
        logic      kind;
        t_elem     element;
        t_check    check;
        t_elem     want_element;
        logic      want_last;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    t_len i_cfg_wdata;

    phc_in_if  in_if ();
    phc_out_if out_if ();

    permutation_half_crossover_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // crossover state as the testbench sees it
    t_map seen_mask   = '0;
    t_len head_count  = '0;
    t_len child_count = '0;
    t_len length_reg  = C_LEN_RESET;

    t_child      pending_child[$];
    t_row        directed_rows[$];
    t_elem       order[C_MAX_LENGTH];
    int unsigned fail_count    = 0;
    int unsigned sent_total    = 0;
    int unsigned burst_left    = 0;
    int unsigned quiet_cycles  = 0;
    bit          steady_tx     = 1'b0;
    t_rx_mode    rx_mode       = RX_COIN;

    always #(CLK_HALF) i_clk = ~i_clk;

    // effective permutation length
    function automatic t_len clamp_length(input t_len value);
        if (value < C_MIN_LENGTH) return C_MIN_LENGTH;
        if (value > t_len'(C_MAX_LENGTH)) return t_len'(C_MAX_LENGTH);
        return value;
    endfunction

    // next child element caused by one parent element
    function automatic void breed_child(input logic kind, input t_elem element,
                                        output logic emit, output logic last);
        t_len span;
        t_len half;
        t_map mark;
        span = clamp_length(length_reg);
        half = span >> 1;
        mark = t_map'(1) << element;
        emit = 1'b0;
        last = 1'b0;
        if (kind == C_KIND_PARENT_ONE) begin
            if (head_count < half) begin
                seen_mask = seen_mask | mark;
                emit = 1'b1;
            end
            if (head_count < C_COUNT_MAX) head_count = head_count + 1'b1;
        end else if ((seen_mask & mark) == '0) begin
            emit = 1'b1;
        end
        if (emit) begin
            child_count = child_count + 1'b1;
            if (child_count >= span) begin
                last = 1'b1;
                seen_mask = '0;
                head_count = '0;
                child_count = '0;
            end
        end
    endfunction

    // random order of 0 .. n-1
    task automatic shuffle_order(input int unsigned n);
        int unsigned idx;
        int unsigned pos;
        t_elem swap;
        for (idx = 0; idx < n; idx++) order[idx] = t_elem'(idx);
        for (idx = n - 1; idx > 0; idx--) begin
            pos = $urandom_range(0, idx);
            swap = order[idx];
            order[idx] = order[pos];
            order[pos] = swap;
        end
    endtask

    // one input transaction, with sender gaps between bursts
    task automatic send_element(input logic kind, input t_elem element, input t_check check,
                                input t_elem want_element, input logic want_last,
                                output logic closed);
        logic   emit;
        logic   last;
        t_child want;
        if (!steady_tx && burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left != 0) burst_left--;
        in_if.valid   <= 1'b1;
        in_if.kind    <= kind;
        in_if.element <= element;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sent_total++;
        breed_child(kind, element, emit, last);
        closed = emit && last;
        case (check)
            CHK_DROP: ;
            CHK_EMIT: begin
                want.element = want_element;
                want.last = want_last;
                pending_child = {pending_child, want};
            end
            default: begin
                if (emit) begin
                    want.element = element;
                    want.last = last;
                    pending_child = {pending_child, want};
                end
            end
        endcase
    endtask

    // wait until every child element is out and the pipe has drained
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_child.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input t_len value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        length_reg = value;
    endtask

    task automatic add_length(input t_len value);
        t_row row;
        row = '0;
        row.row_kind = ROW_CFG;
        row.value = value;
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_element(input logic kind, input t_elem element, input t_check check,
                               input t_elem want_element, input logic want_last);
        t_row row;
        row = '0;
        row.row_kind = ROW_ITEM;
        row.kind = kind;
        row.element = element;
        row.check = check;
        row.want_element = want_element;
        row.want_last = want_last;
        directed_rows = {directed_rows, row};
    endtask

    // stimulus: directed rows, then random phases
    initial begin : stimulus
        t_row        row;
        t_len        value;
        int unsigned span;
        int unsigned pick;
        int unsigned cut;
        int unsigned sent;
        int unsigned head_total;
        int unsigned idx;
        logic        closed;
        logic        kind;
        t_elem       element;
        bit          broken;

        in_if.valid   <= 1'b0;
        in_if.kind    <= C_KIND_PARENT_ONE;
        in_if.element <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= C_LEN_RESET;
        i_rst_n       <= 1'b0;

        // shortest length: head of one, marked and unmarked parent two
        add_length(C_MIN_LENGTH);
        add_element(C_KIND_PARENT_ONE, 6'd63, CHK_EMIT, 6'd63, 1'b0);
        add_element(C_KIND_PARENT_ONE, 6'd0, CHK_DROP, '0, 1'b0);
        add_element(C_KIND_PARENT_TWO, 6'd63, CHK_DROP, '0, 1'b0);
        add_element(C_KIND_PARENT_TWO, 6'd0, CHK_EMIT, 6'd0, 1'b1);
        // length below range, parent two first and repeated
        add_length(7'd0);
        add_element(C_KIND_PARENT_TWO, 6'd5, CHK_EMIT, 6'd5, 1'b0);
        add_element(C_KIND_PARENT_TWO, 6'd5, CHK_EMIT, 6'd5, 1'b1);
        // length above range, child left open
        add_length(C_COUNT_MAX);
        add_element(C_KIND_PARENT_ONE, 6'd21, CHK_MODEL, '0, 1'b0);
        add_element(C_KIND_PARENT_ONE, 6'd42, CHK_MODEL, '0, 1'b0);
        add_element(C_KIND_PARENT_TWO, 6'd21, CHK_DROP, '0, 1'b0);
        add_element(C_KIND_PARENT_TWO, 6'd63, CHK_MODEL, '0, 1'b0);
        // length shrinks below the open child
        add_length(7'd3);
        add_element(C_KIND_PARENT_ONE, 6'd0, CHK_DROP, '0, 1'b0);
        add_element(C_KIND_PARENT_TWO, 6'd42, CHK_DROP, '0, 1'b0);
        add_element(C_KIND_PARENT_TWO, 6'd1, CHK_MODEL, '0, 1'b0);
        // longest length
        add_length(t_len'(C_MAX_LENGTH));
        add_element(C_KIND_PARENT_ONE, 6'd0, CHK_MODEL, '0, 1'b0);
        add_element(C_KIND_PARENT_TWO, 6'd0, CHK_DROP, '0, 1'b0);
        add_element(C_KIND_PARENT_TWO, 6'd63, CHK_MODEL, '0, 1'b0);
        add_element(C_KIND_PARENT_ONE, 6'd42, CHK_MODEL, '0, 1'b0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[idx]) begin
            row = directed_rows[idx];
            if (row.row_kind == ROW_CFG) write_length(row.value);
            else send_element(row.kind, row.element, row.check, row.want_element,
                              row.want_last, closed);
        end

        while (sent_total < ITEM_TARGET) begin
            // new length, mostly small, sometimes the extremes or out of range
            pick = $urandom_range(0, 19);
            case (pick)
                0: value = t_len'(C_MAX_LENGTH);
                1: value = C_MIN_LENGTH;
                2: value = t_len'($urandom_range(0, 1));
                3: value = t_len'($urandom_range(C_MAX_LENGTH + 1, C_COUNT_MAX));
                default: value = t_len'($urandom_range(2, 16));
            endcase
            write_length(value);
            span = 32'(clamp_length(value));
            steady_tx = ($urandom_range(0, 3) == 0);
            rx_mode <= t_rx_mode'($urandom_range(0, 3));

            repeat ($urandom_range(1, 4)) begin
                pick = $urandom_range(0, 59);
                if (pick >= 1 && pick < 9) begin
                    // noise: any kind, any element
                    repeat ($urandom_range(1, 2 * span)) begin
                        kind = 1'($urandom_range(0, 1));
                        element = ($urandom_range(0, 3) == 0) ? t_elem'($urandom_range(0, 63))
                                                               : t_elem'($urandom_range(0, span - 1));
                        send_element(kind, element, CHK_MODEL, '0, 1'b0, closed);
                    end
                end else begin
                    // parent pair, possibly cut short or corrupted, or a flood of parent one
                    broken = (pick >= 9 && pick < 18);
                    head_total = (pick == 0) ? FLOOD_COUNT : span;
                    cut = broken ? $urandom_range(0, 2 * span - 1) : head_total + span;
                    sent = 0;
                    closed = 1'b0;
                    shuffle_order(span);
                    for (idx = 0; idx < head_total && sent < cut; idx++) begin
                        element = order[idx % span];
                        if (broken && $urandom_range(0, 3) == 0)
                            element = t_elem'($urandom_range(0, 63));
                        send_element(C_KIND_PARENT_ONE, element, CHK_MODEL, '0, 1'b0, closed);
                        sent++;
                    end
                    closed = 1'b0;
                    shuffle_order(span);
                    for (idx = 0; idx < span && sent < cut && !closed; idx++) begin
                        kind = C_KIND_PARENT_TWO;
                        if (broken && $urandom_range(0, 7) == 0) kind = C_KIND_PARENT_ONE;
                        send_element(kind, order[idx], CHK_MODEL, '0, 1'b0, closed);
                        sent++;
                    end
                end
            end
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // receiver ready pattern
    initial begin : receiver
        int unsigned tick;
        tick = 0;
        out_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            tick++;
            case (rx_mode)
                RX_STEADY:  out_if.ready <= 1'b1;
                RX_COIN:    out_if.ready <= 1'($urandom_range(0, 1));
                RX_PATTERN: out_if.ready <= (tick % 7 != 0) && (tick % 11 > 2);
                default:    out_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // compare each child transaction with the oldest expected one
    always @(posedge i_clk) begin : child_check
        t_child want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_child.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected child transaction: expected none, got element %0d last %0b",
                         $time, out_if.child_element, out_if.child_last);
            end else begin
                want = pending_child.pop_front();
                if (out_if.child_element !== want.element) begin
                    fail_count++;
                    $display("%0t: child_element mismatch: expected %0d, got %0d",
                             $time, want.element, out_if.child_element);
                end
                if (out_if.child_last !== want.last) begin
                    fail_count++;
                    $display("%0t: child_last mismatch: expected %0b, got %0b",
                             $time, want.last, out_if.child_last);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (in_if.valid && in_if.ready)
                || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/phc_pkg.sv
hdl/phc_in_if.sv
hdl/phc_out_if.sv
hdl/phc_core.sv
hdl/permutation_half_crossover_top.sv
hdl/phc_checker.sv
sim/tb.sv
